/* rtl/core/bis_pkg.sv */
// Shared types, constants and state encodings of the bilinear image scaler core.
// Used by every module under rtl/core except bis_ram; depends on nothing else.
`timescale 1ns / 1ps

package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 64;
  localparam int MAX_SRC_HEIGHT = 64;
  localparam int FRAC_BITS      = 16;

  localparam int POS_W      = 8;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SRC_SIZE_W = 7;
  localparam int DST_SIZE_W = 9;

  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);
  localparam int IDX_W = (XW > YW) ? XW : YW;
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int QUO_W  = SRC_SIZE_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(QUO_W);
  localparam int PROD_W = POS_W + QUO_W;
  localparam int LIM_W  = IDX_W + FRAC_BITS;
  localparam int FR_W   = 8;
  localparam int WT_W   = 2 * (FR_W + 1) - 1;
  localparam int ACC_W  = CH_W + WT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            in_range;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] i1;
    logic [FR_W-1:0]  frac;
  } map_res_t;

  typedef struct packed {
    logic clear;
    logic acc_en;
  } blend_ctl_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_DIV,
    MP_MUL,
    MP_CLAMP
  } map_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC,
    ST_FIN
  } top_state_t;

endpackage

/* rtl/core/bis_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/bis_map.sv */
// Maps one destination index to two source indices and an 8-bit fraction.
// Holds a bit-serial divider for the scale and one multiplier; uses bis_pkg.
`timescale 1ns / 1ps

module bis_map (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [bis_pkg::POS_W-1:0]          d,
  input  logic [bis_pkg::SRC_SIZE_W-1:0]     src,
  input  logic [bis_pkg::DST_SIZE_W-1:0]     dst,
  output logic                               done,
  output bis_pkg::map_res_t                  res
);

  bis_pkg::map_phase_t phase_r, phase_nxt;

  logic [bis_pkg::QUO_W-1:0]      dq_r;
  logic [bis_pkg::DST_SIZE_W-1:0] rem_r;
  logic [bis_pkg::DST_SIZE_W-1:0] dv_r;
  logic [bis_pkg::POS_W-1:0]      d_r;
  logic [bis_pkg::LIM_W-1:0]      lim_r;
  logic [bis_pkg::IDX_W-1:0]      sm1_r;
  logic [bis_pkg::CNT_W-1:0]      cnt_r;
  logic [bis_pkg::PROD_W-1:0]     pos_r;
  logic                           done_r;
  bis_pkg::map_res_t              res_r;

  logic                           div_step, mul_en, clamp_en;
  logic [bis_pkg::DST_SIZE_W:0]   rem_sh, rem_sub;
  logic                           ge;
  logic [bis_pkg::PROD_W-1:0]     posc;
  logic [bis_pkg::IDX_W-1:0]      i0;
  logic [bis_pkg::IDX_W:0]        i1_full;
  bis_pkg::map_res_t              res_nxt;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      bis_pkg::MP_IDLE:  if (start) phase_nxt = bis_pkg::MP_DIV;
      bis_pkg::MP_DIV:   if (cnt_r == bis_pkg::CNT_W'(bis_pkg::QUO_W - 1)) begin
        phase_nxt = bis_pkg::MP_MUL;
      end
      bis_pkg::MP_MUL:   phase_nxt = bis_pkg::MP_CLAMP;
      bis_pkg::MP_CLAMP: phase_nxt = bis_pkg::MP_IDLE;
      default:           phase_nxt = bis_pkg::MP_IDLE;
    endcase
  end

  always_comb begin
    div_step = 1'b0;
    mul_en   = 1'b0;
    clamp_en = 1'b0;
    case (phase_r)
      bis_pkg::MP_DIV:   div_step = 1'b1;
      bis_pkg::MP_MUL:   mul_en   = 1'b1;
      bis_pkg::MP_CLAMP: clamp_en = 1'b1;
      default: ;
    endcase
  end

  // One restoring step: the dividend shifts out of dq_r as quotient bits shift in.
  always_comb begin
    rem_sh  = {rem_r, dq_r[bis_pkg::QUO_W-1]};
    rem_sub = rem_sh - {1'b0, dv_r};
    ge      = (rem_sh >= {1'b0, dv_r});
  end

  always_comb begin
    posc    = (pos_r > bis_pkg::PROD_W'(lim_r)) ? bis_pkg::PROD_W'(lim_r) : pos_r;
    i0      = posc[bis_pkg::FRAC_BITS +: bis_pkg::IDX_W];
    i1_full = {1'b0, i0} + 1'b1;
    res_nxt.i0   = i0;
    res_nxt.i1   = (i1_full > {1'b0, sm1_r}) ? sm1_r : i1_full[bis_pkg::IDX_W-1:0];
    res_nxt.frac = posc[bis_pkg::FRAC_BITS-1 -: bis_pkg::FR_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bis_pkg::MP_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= clamp_en;
      if (start && phase_r == bis_pkg::MP_IDLE) begin
        cnt_r <= '0;
      end else if (div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && phase_r == bis_pkg::MP_IDLE) begin
      dq_r  <= bis_pkg::QUO_W'(src) << bis_pkg::FRAC_BITS;
      rem_r <= '0;
      dv_r  <= dst;
      d_r   <= d;
      sm1_r <= bis_pkg::IDX_W'(src - 1'b1);
      lim_r <= (bis_pkg::LIM_W'(bis_pkg::IDX_W'(src - 1'b1)) << bis_pkg::FRAC_BITS) - 1'b1;
    end else if (div_step) begin
      dq_r  <= {dq_r[bis_pkg::QUO_W-2:0], ge};
      rem_r <= ge ? rem_sub[bis_pkg::DST_SIZE_W-1:0] : rem_sh[bis_pkg::DST_SIZE_W-1:0];
    end
    if (mul_en) begin
      pos_r <= bis_pkg::PROD_W'(d_r) * bis_pkg::PROD_W'(dq_r);
    end
    if (clamp_en) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/core/bis_blend.sv */
// Weighted accumulation of the four neighbour pixels, one pixel per cycle.
// Uses bis_pkg for widths and the control struct.
`timescale 1ns / 1ps

module bis_blend (
  input  logic                          clk,
  input  bis_pkg::blend_ctl_t           ctl,
  input  logic [bis_pkg::PIX_W-1:0]     pix,
  input  logic [bis_pkg::WT_W-1:0]      weight,
  output logic [bis_pkg::PIX_W-1:0]     rgb
);

  logic [bis_pkg::ACC_W-1:0] acc_r [3];

  // The clear value carries the half-LSB for rounding half up.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (ctl.clear) begin
        acc_r[ch] <= bis_pkg::ACC_W'(1) << (bis_pkg::WT_W - 2);
      end else if (ctl.acc_en) begin
        acc_r[ch] <= acc_r[ch] +
                     bis_pkg::ACC_W'(pix[(2 - ch) * bis_pkg::CH_W +: bis_pkg::CH_W]) *
                     bis_pkg::ACC_W'(weight);
      end
    end
  end

  // The weights sum to one in 16 fraction bits, so the channel sits above them.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rgb[(2 - ch) * bis_pkg::CH_W +: bis_pkg::CH_W] =
        acc_r[ch][bis_pkg::ACC_W-1] ? {bis_pkg::CH_W{1'b1}}
                                    : acc_r[ch][bis_pkg::WT_W-1 +: bis_pkg::CH_W];
    end
  end

endmodule

/* rtl/core/bilinear_image_scaler_core.sv */
// Top level of the bilinear image scaler: frame store, two coordinate mappers,
// the blend accumulator and the request sequencer. Uses bis_pkg, bis_ram,
// bis_map and bis_blend.
`timescale 1ns / 1ps

// How the block is used
// The input channel (in_valid, in_stall, in_data) carries two kinds of request.
// A write request (opcode 0) stores one RGB pixel in the 64 x 64 frame store and
// produces no result; the block stays idle, so writes can stream one per cycle
// while no pixel request is in progress. A pixel request (opcode 1) produces
// exactly one result on the output channel (out_valid, out_stall, out_data). A
// request outside the destination size gives zeros with in_range low. A request
// inside it passes through the bit-serial scale divider, one multiply, one clamp,
// one weight stage and four reads of the single-port frame store, followed by the
// final accumulation and output load. The block works on one request at a time
// and holds in_stall high meanwhile, so the next request is taken only once the
// result of a pixel request has been loaded into the output register.
// The result sits in an output register, so a new request is taken while the
// receiver stalls; the sequencer only waits if a second result is ready before
// the first has been taken. Configuration writes (cfg_we, cfg_index, cfg_wdata)
// are taken in any cycle and must only be issued while the block is idle.
// A synchronous active-low reset restores the default sizes (4 x 4 source,
// 6 x 6 destination) and empties the output; the frame store is not cleared,
// and each pixel must be written before a request reads it.

module bilinear_image_scaler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bis_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bis_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic [bis_pkg::SRC_SIZE_W-1:0] src_width_r, src_height_r;
  logic [bis_pkg::DST_SIZE_W-1:0] dst_width_r, dst_height_r;

  // Sequencer state and per-request registers.
  bis_pkg::top_state_t state_r, state_nxt;
  logic                      zero_r;
  logic [bis_pkg::WT_W-1:0]  w00_r, w10_r, w01_r, w11_r;
  logic                      out_valid_r;
  bis_pkg::out_item_t        out_data_r;

  // Combinational control.
  logic                           in_accept, is_write, in_dst;
  logic [bis_pkg::SRC_SIZE_W-1:0] sw, sh;
  logic                           map_start, load_out;
  logic                           ram_we;
  logic [bis_pkg::STORE_AW-1:0]   ram_addr;
  logic [bis_pkg::PIX_W-1:0]      ram_wdata, ram_rdata;
  logic [bis_pkg::WT_W-1:0]       blend_w;
  bis_pkg::blend_ctl_t            blend_ctl;
  logic [bis_pkg::PIX_W-1:0]      blend_rgb;
  logic                           x_done, y_done;
  bis_pkg::map_res_t              x_res, y_res;
  logic [bis_pkg::FR_W:0]         fx_c, fy_c;

  // The source size is clamped to the range 2 up to the store dimensions, for writes and reads.
  always_comb begin
    if (src_width_r < bis_pkg::SRC_SIZE_W'(2)) begin
      sw = bis_pkg::SRC_SIZE_W'(2);
    end else if (src_width_r > bis_pkg::SRC_SIZE_W'(bis_pkg::MAX_SRC_WIDTH)) begin
      sw = bis_pkg::SRC_SIZE_W'(bis_pkg::MAX_SRC_WIDTH);
    end else begin
      sw = src_width_r;
    end
    if (src_height_r < bis_pkg::SRC_SIZE_W'(2)) begin
      sh = bis_pkg::SRC_SIZE_W'(2);
    end else if (src_height_r > bis_pkg::SRC_SIZE_W'(bis_pkg::MAX_SRC_HEIGHT)) begin
      sh = bis_pkg::SRC_SIZE_W'(bis_pkg::MAX_SRC_HEIGHT);
    end else begin
      sh = src_height_r;
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign is_write  = (in_data.opcode == bis_pkg::OP_WRITE);
  assign in_dst    = ({1'b0, in_data.pos_x} < dst_width_r) &&
                     ({1'b0, in_data.pos_y} < dst_height_r);
  // The output register is free when empty or being emptied in this cycle.
  assign load_out  = (state_r == bis_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bis_pkg::ST_IDLE: begin
        if (in_accept && !is_write) begin
          state_nxt = in_dst ? bis_pkg::ST_MAP : bis_pkg::ST_FIN;
        end
      end
      bis_pkg::ST_MAP:  if (x_done && y_done) state_nxt = bis_pkg::ST_RD0;
      bis_pkg::ST_RD0:  state_nxt = bis_pkg::ST_RD1;
      bis_pkg::ST_RD1:  state_nxt = bis_pkg::ST_RD2;
      bis_pkg::ST_RD2:  state_nxt = bis_pkg::ST_RD3;
      bis_pkg::ST_RD3:  state_nxt = bis_pkg::ST_ACC;
      bis_pkg::ST_ACC:  state_nxt = bis_pkg::ST_FIN;
      bis_pkg::ST_FIN:  if (load_out) state_nxt = bis_pkg::ST_IDLE;
      default:          state_nxt = bis_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. Each read issued in one state is accumulated in the
  // next, together with the weight that belongs to that neighbour.
  always_comb begin
    in_stall        = (state_r != bis_pkg::ST_IDLE);
    map_start       = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = {in_data.pos_y[bis_pkg::YW-1:0], in_data.pos_x[bis_pkg::XW-1:0]};
    blend_ctl.clear = 1'b0;
    blend_ctl.acc_en = 1'b0;
    blend_w         = w00_r;
    case (state_r)
      bis_pkg::ST_IDLE: begin
        map_start = in_accept && !is_write && in_dst;
        ram_we    = in_accept && is_write &&
                    (in_data.pos_x < {1'b0, sw}) &&
                    (in_data.pos_y < {1'b0, sh});
      end
      bis_pkg::ST_RD0: begin
        ram_addr        = {y_res.i0[bis_pkg::YW-1:0], x_res.i0[bis_pkg::XW-1:0]};
        blend_ctl.clear = 1'b1;
      end
      bis_pkg::ST_RD1: begin
        ram_addr         = {y_res.i0[bis_pkg::YW-1:0], x_res.i1[bis_pkg::XW-1:0]};
        blend_ctl.acc_en = 1'b1;
        blend_w          = w00_r;
      end
      bis_pkg::ST_RD2: begin
        ram_addr         = {y_res.i1[bis_pkg::YW-1:0], x_res.i0[bis_pkg::XW-1:0]};
        blend_ctl.acc_en = 1'b1;
        blend_w          = w10_r;
      end
      bis_pkg::ST_RD3: begin
        ram_addr         = {y_res.i1[bis_pkg::YW-1:0], x_res.i1[bis_pkg::XW-1:0]};
        blend_ctl.acc_en = 1'b1;
        blend_w          = w01_r;
      end
      bis_pkg::ST_ACC: begin
        blend_ctl.acc_en = 1'b1;
        blend_w          = w11_r;
      end
      default: ;
    endcase
  end

  assign ram_wdata = {in_data.in_red, in_data.in_green, in_data.in_blue};

  // Complementary fractions, 256 - f, for the weights.
  assign fx_c = (bis_pkg::FR_W + 1)'(1 << bis_pkg::FR_W) - {1'b0, x_res.frac};
  assign fy_c = (bis_pkg::FR_W + 1)'(1 << bis_pkg::FR_W) - {1'b0, y_res.frac};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bis_pkg::SRC_SIZE_W'(4);
      src_height_r <= bis_pkg::SRC_SIZE_W'(4);
      dst_width_r  <= bis_pkg::DST_SIZE_W'(6);
      dst_height_r <= bis_pkg::DST_SIZE_W'(6);
      state_r      <= bis_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[bis_pkg::SRC_SIZE_W-1:0];
          bis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[bis_pkg::SRC_SIZE_W-1:0];
          bis_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[bis_pkg::DST_SIZE_W-1:0];
          bis_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[bis_pkg::DST_SIZE_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == bis_pkg::ST_IDLE && in_accept && !is_write) begin
      zero_r <= !in_dst;
    end
    if (state_r == bis_pkg::ST_RD0) begin
      w00_r <= bis_pkg::WT_W'(fx_c) * bis_pkg::WT_W'(fy_c);
      w10_r <= bis_pkg::WT_W'(x_res.frac) * bis_pkg::WT_W'(fy_c);
      w01_r <= bis_pkg::WT_W'(fx_c) * bis_pkg::WT_W'(y_res.frac);
      w11_r <= bis_pkg::WT_W'(x_res.frac) * bis_pkg::WT_W'(y_res.frac);
    end
    if (load_out) begin
      if (zero_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r.out_red   <= blend_rgb[2 * bis_pkg::CH_W +: bis_pkg::CH_W];
        out_data_r.out_green <= blend_rgb[bis_pkg::CH_W +: bis_pkg::CH_W];
        out_data_r.out_blue  <= blend_rgb[0 +: bis_pkg::CH_W];
        out_data_r.in_range  <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bis_ram #(
    .WIDTH (bis_pkg::PIX_W),
    .DEPTH (bis_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bis_map u_map_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (map_start),
    .d     (in_data.pos_x),
    .src   (sw),
    .dst   (dst_width_r),
    .done  (x_done),
    .res   (x_res)
  );

  bis_map u_map_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (map_start),
    .d     (in_data.pos_y),
    .src   (sh),
    .dst   (dst_height_r),
    .done  (y_done),
    .res   (y_res)
  );

  bis_blend u_blend (
    .clk    (clk),
    .ctl    (blend_ctl),
    .pix    (ram_rdata),
    .weight (blend_w),
    .rgb    (blend_rgb)
  );

endmodule
